### rtl/otp_pkg.sv
package otp_pkg;

   // field widths fixed by the channel definitions
   localparam int ACTION_BITS  = 2;
   localparam int HEADING_BITS = 16;
   localparam int RATE_BITS    = 16;
   localparam int GOAL_BITS    = 20;
   localparam int SPEED_BITS   = 15;
   localparam int RAMP_BITS    = 19;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = GOAL_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GOAL_ANGLE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TURN_SPEED = 1'd1;
   localparam logic [SPEED_BITS-1:0]     TURN_SPEED_RESET = 15'd614;

   // action codes
   localparam logic [ACTION_BITS-1:0] ACT_HEADING = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_START   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_PREEMPT = 2'd2;

   // phase codes
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_ARMING  = 2'd1;
   localparam logic [1:0] PH_TURNING = 2'd2;
   localparam logic [1:0] PH_ENDING  = 2'd3;

   // minimum nonzero command, 0.025 rad/s in Q4.12
   localparam logic [SPEED_BITS-1:0] STALL_RATE = 15'd102;

   // ramp scaling: speed shifted to 2^(angle_bits-14) scale, then divided by 9
   localparam int RAMP_NUM_BITS  = 25;
   localparam int RAMP_BASE_BITS = 22;
   localparam int DIV9_SHIFT     = 29;
   localparam int DIV9_MUL_BITS  = 26;
   localparam logic [DIV9_MUL_BITS-1:0] DIV9_MUL = 26'd59652324;

   // speed divided by 3 by reciprocal multiply
   localparam int DIV3_SHIFT    = 17;
   localparam int DIV3_MUL_BITS = 16;
   localparam logic [DIV3_MUL_BITS-1:0] DIV3_MUL = 16'd43691;

endpackage

### rtl/otp_req_if.sv
interface otp_req_if
   import otp_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [ACTION_BITS-1:0]  action;
   logic [HEADING_BITS-1:0] heading;

   modport source (output valid, output action, output heading, input ready);
   modport sink (input valid, input action, input heading, output ready);
endinterface

### rtl/otp_rsp_if.sv
interface otp_rsp_if
   import otp_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic signed [RATE_BITS-1:0] turn_rate;
   logic                        complete;

   modport source (output valid, output turn_rate, output complete, input ready);
   modport sink (input valid, input turn_rate, input complete, output ready);
endinterface

### rtl/odometry_turn_profiler.sv
// channel   direction   payload                      handshake
// req       in          action[1:0], heading[15:0]   valid/ready
// rsp       out         turn_rate[15:0] s, complete  valid/ready
// csr       in          index[0], data[19:0]         write enable only
//
// one transaction per cycle while rsp is ready; rsp valid is registered after the input stage
// the per-item path is one saturating add of the heading change into progress and three compares
// synchronous active-high reset idles the phase; state, config and valid registers go to defaults
// req is ready while the input stage is empty or the output register is empty or being taken
// ramp and speed/3 terms are registered off the speed register, so they follow a speed write
module odometry_turn_profiler
   import otp_pkg::*;
#(
   parameter int ANGLE_BITS    = 16,
   parameter int PROGRESS_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   otp_req_if.sink                   req,
   otp_rsp_if.source                 rsp,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int SUM_W = ((ANGLE_BITS > PROGRESS_BITS) ? ANGLE_BITS : PROGRESS_BITS) + 1;
   localparam int CMP_W = ((PROGRESS_BITS > GOAL_BITS + 1) ? PROGRESS_BITS : GOAL_BITS + 1) + 2;
   localparam logic signed [SUM_W-1:0] P_HI =
      {{(SUM_W-PROGRESS_BITS+1){1'b0}}, {(PROGRESS_BITS-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] P_LO = ~P_HI;
   localparam int RAMP_PROD_W  = RAMP_NUM_BITS + DIV9_MUL_BITS;
   localparam int THIRD_PROD_W = SPEED_BITS + DIV3_MUL_BITS;

   // configuration registers
   logic signed [GOAL_BITS-1:0] goal_ff;
   logic [SPEED_BITS-1:0]       speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff  <= '0;
         speed_ff <= TURN_SPEED_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GOAL_ANGLE: goal_ff <= csr_data;
            CSR_TURN_SPEED: speed_ff <= csr_data[SPEED_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ramp base = speed * 10 * 2^angle_bits / (360 * 4096), as shifted speed / 9
   logic [RAMP_NUM_BITS-1:0]  ramp_num;
   logic [RAMP_PROD_W-1:0]    ramp_prod;
   logic [RAMP_BASE_BITS-1:0] ramp_base_ff;
   logic [THIRD_PROD_W-1:0]   third_prod;
   logic [SPEED_BITS-1:0]     third_ff;

   if (ANGLE_BITS >= 14) begin : g_num_up
      assign ramp_num = RAMP_NUM_BITS'(speed_ff) << (ANGLE_BITS - 14);
   end else begin : g_num_dn
      assign ramp_num = RAMP_NUM_BITS'(speed_ff) >> (14 - ANGLE_BITS);
   end

   assign ramp_prod  = RAMP_PROD_W'(ramp_num) * RAMP_PROD_W'(DIV9_MUL);
   assign third_prod = THIRD_PROD_W'(speed_ff) * THIRD_PROD_W'(DIV3_MUL);

   always_ff @(posedge clock) begin
      ramp_base_ff <= ramp_prod[DIV9_SHIFT +: RAMP_BASE_BITS];
      third_ff     <= third_prod[DIV3_SHIFT +: SPEED_BITS];
   end

   // handshake and stage control
   logic                    in_vld_ff;
   logic [ACTION_BITS-1:0]  act_ff;
   logic [HEADING_BITS-1:0] hdg_ff;
   logic                    out_vld_ff;
   logic                    out_free;
   logic                    proc;
   logic                    req_fire;

   assign out_free  = !out_vld_ff || rsp.ready;
   assign proc      = in_vld_ff && out_free;
   assign req.ready = !in_vld_ff || out_free;
   assign req_fire  = req.valid && req.ready;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_fire) begin
         in_vld_ff <= 1'b1;
      end else if (proc) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff <= req.action;
         hdg_ff <= req.heading;
      end
   end

   // turn state
   logic [1:0]                     phase_ff, phase_in;
   logic signed [PROGRESS_BITS-1:0] progress_ff, progress_in;
   logic [ANGLE_BITS-1:0]          prev_ff, prev_in;
   logic [RAMP_BITS-1:0]           ramp_ff, ramp_in;

   // goal magnitude
   logic [GOAL_BITS-1:0] agoal;
   assign agoal = goal_ff[GOAL_BITS-1] ? GOAL_BITS'(-goal_ff) : GOAL_BITS'(goal_ff);

   // ramp capped at half the goal
   logic [RAMP_BASE_BITS:0] ramp_twice;
   logic [RAMP_BITS-1:0]    ramp_new;
   assign ramp_twice = {ramp_base_ff, 1'b0};
   assign ramp_new   = ((RAMP_BASE_BITS+1)'(ramp_twice) > (RAMP_BASE_BITS+1)'(agoal))
                       ? RAMP_BITS'(agoal >> 1) : RAMP_BITS'(ramp_base_ff);

   // shortest heading change and saturating progress update
   logic [ANGLE_BITS-1:0]           hd;
   logic [ANGLE_BITS-1:0]           delta;
   logic signed [SUM_W-1:0]         sum;
   logic signed [PROGRESS_BITS-1:0] p_new;
   logic [PROGRESS_BITS-1:0]        p_abs;

   assign hd    = ANGLE_BITS'(hdg_ff);
   assign delta = hd - prev_ff;
   assign sum   = SUM_W'(signed'(delta)) + SUM_W'(progress_ff);

   always_comb begin
      if (sum > P_HI) begin
         p_new = PROGRESS_BITS'(P_HI);
      end else if (sum < P_LO) begin
         p_new = PROGRESS_BITS'(P_LO);
      end else begin
         p_new = PROGRESS_BITS'(sum);
      end
   end

   assign p_abs = p_new[PROGRESS_BITS-1] ? PROGRESS_BITS'(-p_new) : PROGRESS_BITS'(p_new);

   // level decisions as thresholds on the progress magnitude
   logic signed [CMP_W-1:0] abs_s, abs2_s, goal_s, ramp_s, thr_stop, thr_third;
   logic                    lvl_stop, lvl_third, lvl_half;

   assign abs_s     = signed'(CMP_W'(p_abs));
   assign abs2_s    = abs_s <<< 1;
   assign goal_s    = signed'(CMP_W'(agoal));
   assign ramp_s    = signed'(CMP_W'(ramp_ff));
   assign thr_stop  = goal_s - ramp_s;
   assign thr_third = goal_s - (ramp_s <<< 1);
   assign lvl_stop  = abs_s > thr_stop;
   assign lvl_third = abs_s > thr_third;
   assign lvl_half  = abs2_s > goal_s;

   // magnitude to signed command with stall floor
   logic [SPEED_BITS-1:0]       mag_sel, mag_flr;
   logic signed [RATE_BITS-1:0] rate_cmd;

   always_comb begin
      if (phase_ff == PH_ARMING) begin
         mag_sel = speed_ff;
      end else if (lvl_third) begin
         mag_sel = third_ff;
      end else if (lvl_half) begin
         mag_sel = speed_ff >> 1;
      end else begin
         mag_sel = speed_ff;
      end
   end

   assign mag_flr  = (mag_sel < STALL_RATE) ? STALL_RATE : mag_sel;
   assign rate_cmd = goal_ff[GOAL_BITS-1] ? -signed'(RATE_BITS'(mag_flr))
                                          : signed'(RATE_BITS'(mag_flr));

   // per-transaction decision
   logic                        res_vld;
   logic signed [RATE_BITS-1:0] res_rate;
   logic                        res_done;

   always_comb begin
      phase_in    = phase_ff;
      progress_in = progress_ff;
      prev_in     = prev_ff;
      ramp_in     = ramp_ff;
      res_vld     = 1'b0;
      res_rate    = '0;
      res_done    = 1'b0;
      case (act_ff)
         ACT_START: begin
            ramp_in  = ramp_new;
            phase_in = PH_ARMING;
         end
         ACT_PREEMPT: begin
            phase_in = PH_IDLE;
            res_vld  = 1'b1;
         end
         ACT_HEADING: begin
            case (phase_ff)
               PH_ARMING: begin
                  progress_in = '0;
                  prev_in     = hd;
                  phase_in    = PH_TURNING;
                  res_vld     = 1'b1;
                  res_rate    = rate_cmd;
               end
               PH_TURNING: begin
                  progress_in = p_new;
                  prev_in     = hd;
                  res_vld     = 1'b1;
                  if (lvl_stop) begin
                     phase_in = PH_ENDING;
                  end else begin
                     res_rate = rate_cmd;
                  end
               end
               PH_ENDING: begin
                  progress_in = p_new;
                  phase_in    = PH_IDLE;
                  res_vld     = 1'b1;
                  res_done    = 1'b1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         progress_ff <= '0;
         prev_ff     <= '0;
         ramp_ff     <= '0;
      end else if (proc) begin
         phase_ff    <= phase_in;
         progress_ff <= progress_in;
         prev_ff     <= prev_in;
         ramp_ff     <= ramp_in;
      end
   end

   // result register
   logic signed [RATE_BITS-1:0] rate_ff;
   logic                        done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (proc) begin
         out_vld_ff <= res_vld;
      end else if (rsp.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         rate_ff <= res_rate;
         done_ff <= res_done;
      end
   end

   assign rsp.valid     = out_vld_ff;
   assign rsp.turn_rate = rate_ff;
   assign rsp.complete  = done_ff;

endmodule
